FILE: hdl/integer_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii assertion macros
// Shared property wrappers for the converter checkers.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH
`define INTEGER_TO_DECIMAL_ASCII_ASSERT_SVH

// condition seen, consequence due on the next clock
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition seen, consequence due on the same clock
`define ITOA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: hdl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int unsigned DIGIT_BITS = 4;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_NINE  = 8'd57;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;

	localparam logic [DIGIT_BITS-1:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [DIGIT_BITS-1:0] BCD_ADJ     = 4'd3;

	// decimal digits needed for 2**bits - 1, i.e. floor(bits * log10(2)) + 1
	function automatic int unsigned dec_digits(input int unsigned bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

endpackage

FILE: hdl/itoa_bcd_conv.sv
// ----------------------------------------------------------------------------
// itoa_bcd_conv
// Bit-serial binary to BCD conversion (shift and add 3), one bit per cycle.
// ----------------------------------------------------------------------------
module itoa_bcd_conv #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] mag,
	output logic                 done,
	output logic [itoa_pkg::dec_digits(WORD_BITS)*itoa_pkg::DIGIT_BITS-1:0] bcd
);
	import itoa_pkg::*;

	localparam int NDIG  = dec_digits(WORD_BITS);
	localparam int BCD_W = NDIG * DIGIT_BITS;
	localparam int CNT_W = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] mag_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_W-1:0]     adj;
	logic [CNT_W-1:0]     cnt_q;
	logic                 run_q;
	logic                 done_q;

	// every digit of five or more gets 3 added before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i*DIGIT_BITS +: DIGIT_BITS] =
				(bcd_q[i*DIGIT_BITS +: DIGIT_BITS] >= BCD_ADJ_MIN) ?
				bcd_q[i*DIGIT_BITS +: DIGIT_BITS] + BCD_ADJ :
				bcd_q[i*DIGIT_BITS +: DIGIT_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(WORD_BITS);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			mag_q <= mag_q << 1;
			bcd_q <= {adj[BCD_W-2:0], mag_q[WORD_BITS-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

FILE: hdl/integer_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts one word to its decimal ASCII text, one character per transfer.
// ----------------------------------------------------------------------------
// Input channel src_valid/src_ready carries value and is_signed; only the low
// WORD_BITS bits of value are used. is_signed reads them as two's complement.
// Output channel dst_valid/dst_ready carries one character per transfer, most
// significant first, no leading zeros; a negative signed word starts with
// '-'. last marks the final character of each number.
// One word is converted at a time: src_ready is high only while idle. The
// magnitude is converted by a shift-and-add-3 register, one bit per cycle;
// leading zero digits are then skipped, one per cycle, and the characters
// follow, the sign first if there is one. The output register lets the
// next word be taken while the last character still waits. A stalled
// receiver holds the character and last, and conversion of further
// characters waits. Reset empties the output register and returns to
// idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii #(
	parameter int WORD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [31:0] value,
	input  logic        is_signed,
	output logic        dst_valid,
	input  logic        dst_ready,
	output logic [7:0]  character,
	output logic        last
);
	import itoa_pkg::*;

	localparam int NDIG  = dec_digits(WORD_BITS);
	localparam int BCD_W = NDIG * DIGIT_BITS;
	localparam int LEFT_W = $clog2(NDIG + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CONV = 5'b00010,
		ST_SKIP = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] mag;
	logic                 neg_in;
	logic                 accept;
	logic                 conv_done;
	logic [BCD_W-1:0]     bcd;

	logic [BCD_W-1:0]      digits_q;
	logic [LEFT_W-1:0]     left_q;
	logic                  neg_q;
	logic [DIGIT_BITS-1:0] top_dig;
	logic                  skip;
	logic                  out_free;
	logic                  load;
	logic [7:0]            ch_next;
	logic                  last_next;

	logic       out_valid_q;
	logic [7:0] character_q;
	logic       last_q;

	assign src_ready = (state_q == ST_IDLE);
	assign accept    = src_valid && src_ready;

	assign word   = WORD_BITS'(value);
	assign neg_in = is_signed && word[WORD_BITS-1];
	// negation modulo 2**WORD_BITS also gives the right magnitude for the most negative word
	assign mag    = neg_in ? ('0 - word) : word;

	itoa_bcd_conv #(
		.WORD_BITS(WORD_BITS)
	) u_conv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.mag   (mag),
		.done  (conv_done),
		.bcd   (bcd)
	);

	assign top_dig  = digits_q[BCD_W-1 -: DIGIT_BITS];
	// leading zeros go, but the units digit always stays
	assign skip     = (top_dig == '0) && (left_q != LEFT_W'(1));
	assign out_free = !out_valid_q || dst_ready;

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		ch_next   = ASCII_ZERO + 8'(top_dig);
		last_next = (left_q == LEFT_W'(1));
		unique case (state_q)
			ST_IDLE: begin
				if (src_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!skip) state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (out_free) begin
					load      = 1'b1;
					ch_next   = ASCII_MINUS;
					last_next = 1'b0;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (left_q == LEFT_W'(1)) state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (dst_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) neg_q <= neg_in;
		if (load) begin
			character_q <= ch_next;
			last_q      <= last_next;
		end
		if (state_q == ST_CONV && conv_done) begin
			digits_q <= bcd;
			left_q   <= LEFT_W'(NDIG);
		end else if ((state_q == ST_SKIP && skip) || (state_q == ST_EMIT && out_free)) begin
			digits_q <= {digits_q[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
			left_q   <= left_q - LEFT_W'(1);
		end
	end

	assign dst_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

endmodule

FILE: hdl/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_decimal_ascii_assert.svh"

module itoa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       src_valid,
	input logic       src_ready,
	input logic       dst_valid,
	input logic       dst_ready,
	input logic [7:0] character,
	input logic       last
);
	import itoa_pkg::*;

	// a stalled character must hold
	`ITOA_ASSERT_NEXT(a_dst_hold, dst_valid && !dst_ready,
		dst_valid && $stable(character) && $stable(last), "stalled character changed")

	// one word at a time: no new request right after one is taken
	`ITOA_ASSERT_NEXT(a_src_busy, src_valid && src_ready, !src_ready,
		"request taken while converting")

	// mid-number characters mean the block is still busy
	`ITOA_ASSERT_IMPL(a_busy_mid, dst_valid && !last, !src_ready,
		"ready while a number is still being sent")

	// only digits or the sign, and the sign never ends a number
	`ITOA_ASSERT_IMPL(a_char_set, dst_valid,
		((character >= ASCII_ZERO) && (character <= ASCII_NINE)) ||
		((character == ASCII_MINUS) && !last), "bad character")

endmodule

bind integer_to_decimal_ascii itoa_checker u_itoa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.src_valid(src_valid),
	.src_ready(src_ready),
	.dst_valid(dst_valid),
	.dst_ready(dst_ready),
	.character(character),
	.last     (last)
);
